/* src/pllm_pkg.sv */
// Shared types and constants for the pooled linked list manager.
package pllm_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int CUR_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Slave-side tdata layout, lowest bit first
    localparam int S_CMD_LSB  = 0;
    localparam int S_DATA_LSB = S_CMD_LSB + CMD_W;
    localparam int S_CUR_LSB  = S_DATA_LSB + DATA_W;
    localparam int S_HEAD_BIT = S_CUR_LSB + CUR_W;
    localparam int S_USED_W   = S_HEAD_BIT + 1;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata layout, lowest bit first
    localparam int M_STATUS_LSB = 0;
    localparam int M_VALUE_LSB  = M_STATUS_LSB + STATUS_W;
    localparam int M_CUR_LSB    = M_VALUE_LSB + DATA_W;
    localparam int M_HEAD_BIT   = M_CUR_LSB + CUR_W;
    localparam int M_COUNT_LSB  = M_HEAD_BIT + 1;
    localparam int M_EMPTY_BIT  = M_COUNT_LSB + COUNT_W;
    localparam int M_USED_W     = M_EMPTY_BIT + 1;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_READ       = 3'd2,
        CMD_WRITE      = 3'd3,
        CMD_ADVANCE    = 3'd4,
        CMD_INSERT     = 3'd5,
        CMD_REMOVE     = 3'd6,
        CMD_END        = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_ELEM = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     command;
        logic signed [DATA_W-1:0] data_value;
        logic [CUR_W-1:0]         cursor_index;
        logic                     cursor_at_head;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [CUR_W-1:0]         new_cursor_index;
        logic                     new_cursor_at_head;
        logic [COUNT_W-1:0]       element_count;
        logic                     list_empty;
    } t_rsp;

endpackage

/* src/pllm_pool.sv */
// Entry pool with link and value register files, list pointers and command execution.
module pllm_pool
    import pllm_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

    typedef logic [PW-1:0] t_ptr;

    t_ptr                   r_link [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_value [CAPACITY];
    t_ptr                   r_head;
    t_ptr                   r_tail;
    t_ptr                   r_free;
    t_ptr                   r_count;

    t_ptr n_head;
    t_ptr n_tail;
    t_ptr n_free;
    t_ptr n_count;

    logic          wa_en;
    logic [IW-1:0] wa_idx;
    t_ptr          wa_data;
    logic          wb_en;
    logic [IW-1:0] wb_idx;
    t_ptr          wb_data;
    logic                   vw_en;
    logic [IW-1:0]          vw_idx;
    logic [VALUE_WIDTH-1:0] val;

    t_cmd          cmd;
    logic          at_head;
    logic          bad;
    logic [IW-1:0] pidx;
    t_ptr          prev_ptr;
    t_ptr          el;
    logic          el_null;
    logic [IW-1:0] el_idx;
    t_ptr          link_el;
    logic          free_null;
    logic [IW-1:0] new_idx;
    t_ptr          free_next;
    t_ptr          ins_el;
    logic          tail_null;

    t_status               status;
    logic [DATA_W-1:0]     rv;
    logic [CUR_W-1:0]      oi;
    logic                  oh;

    assign cmd       = i_req.command;
    assign at_head   = i_req.cursor_at_head;
    assign bad       = !at_head && (int'(i_req.cursor_index) >= CAPACITY);
    assign pidx      = IW'(i_req.cursor_index);
    assign prev_ptr  = at_head ? NULL_PTR : PW'(pidx);
    assign val       = VALUE_WIDTH'($unsigned(i_req.data_value));

    assign el        = at_head ? r_head : r_link[pidx];
    assign el_null   = (el >= NULL_PTR);
    assign el_idx    = el[IW-1:0];
    assign link_el   = r_link[el_idx];

    assign free_null = (r_free >= NULL_PTR);
    assign new_idx   = r_free[IW-1:0];
    assign free_next = r_link[new_idx];
    assign tail_null = (r_tail >= NULL_PTR);

    // The freshly taken entry reads as null when the cursor sits on it
    assign ins_el = at_head ? r_head : ((pidx == new_idx) ? NULL_PTR : r_link[pidx]);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_free  = r_free;
        n_count = r_count;
        wa_en   = 1'b0;
        wa_idx  = '0;
        wa_data = NULL_PTR;
        wb_en   = 1'b0;
        wb_idx  = '0;
        wb_data = NULL_PTR;
        vw_en   = 1'b0;
        vw_idx  = new_idx;
        status  = ST_OK;
        rv      = '0;
        oi      = at_head ? '0 : i_req.cursor_index;
        oh      = at_head;

        if (bad && (cmd inside {[CMD_READ:CMD_REMOVE]})) begin
            status = ST_NO_ELEM;
        end else begin
            case (cmd)
                CMD_PUSH_FRONT: begin
                    if (free_null) begin
                        status = ST_FULL;
                    end else begin
                        n_free  = free_next;
                        wb_en   = 1'b1;
                        wb_idx  = new_idx;
                        wb_data = r_head;
                        n_head  = r_free;
                        if (r_count == '0) begin
                            n_tail = r_free;
                        end
                        vw_en = 1'b1;
                        if (r_count < NULL_PTR) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                CMD_PUSH_BACK: begin
                    if (free_null) begin
                        status = ST_FULL;
                    end else begin
                        n_free  = free_next;
                        wa_en   = 1'b1;
                        wa_idx  = new_idx;
                        wa_data = NULL_PTR;
                        // Tail link write wins when the tail names the taken entry
                        if (!tail_null) begin
                            wb_en   = 1'b1;
                            wb_idx  = r_tail[IW-1:0];
                            wb_data = r_free;
                        end else begin
                            n_head = r_free;
                        end
                        n_tail = r_free;
                        vw_en  = 1'b1;
                        if (r_count < NULL_PTR) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    if (el_null) begin
                        status = ST_NO_ELEM;
                    end else begin
                        rv = DATA_W'(r_value[el_idx]);
                    end
                end
                CMD_WRITE: begin
                    if (el_null) begin
                        status = ST_NO_ELEM;
                    end else begin
                        vw_en  = 1'b1;
                        vw_idx = el_idx;
                    end
                end
                CMD_ADVANCE: begin
                    if (el_null) begin
                        status = ST_NO_ELEM;
                        oi     = '0;
                        oh     = 1'b1;
                    end else begin
                        oi = CUR_W'(el);
                        oh = 1'b0;
                    end
                end
                CMD_INSERT: begin
                    if (free_null) begin
                        status = ST_FULL;
                    end else begin
                        n_free = free_next;
                        if (prev_ptr == r_tail) begin
                            n_tail = r_free;
                        end
                        if (at_head) begin
                            n_head = r_free;
                        end else begin
                            wa_en   = 1'b1;
                            wa_idx  = pidx;
                            wa_data = r_free;
                        end
                        wb_en   = 1'b1;
                        wb_idx  = new_idx;
                        wb_data = ins_el;
                        vw_en   = 1'b1;
                        if (r_count < NULL_PTR) begin
                            n_count = r_count + 1'b1;
                        end
                        oi = CUR_W'(r_free);
                        oh = 1'b0;
                    end
                end
                CMD_REMOVE: begin
                    if (el_null) begin
                        status = ST_NO_ELEM;
                    end else begin
                        if (el == r_tail) begin
                            n_tail = prev_ptr;
                        end
                        if (at_head) begin
                            n_head = link_el;
                        end else begin
                            wa_en   = 1'b1;
                            wa_idx  = pidx;
                            wa_data = link_el;
                        end
                        // Return the entry to the front of the free chain
                        wb_en   = 1'b1;
                        wb_idx  = el_idx;
                        wb_data = r_free;
                        n_free  = el;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                CMD_END: begin
                    if (tail_null) begin
                        oi = '0;
                        oh = 1'b1;
                    end else begin
                        oi = CUR_W'(r_tail);
                        oh = 1'b0;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.status             = status;
        o_rsp.read_value         = rv;
        o_rsp.new_cursor_index   = oi;
        o_rsp.new_cursor_at_head = oh;
        o_rsp.element_count      = COUNT_W'(n_count);
        o_rsp.list_empty         = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_link[i] <= (i == 0) ? NULL_PTR : PW'(i - 1);
            end
            r_head  <= NULL_PTR;
            r_tail  <= NULL_PTR;
            r_free  <= PW'(CAPACITY - 1);
            r_count <= '0;
        end else if (i_req_valid) begin
            if (wa_en) begin
                r_link[wa_idx] <= wa_data;
            end
            if (wb_en) begin
                r_link[wb_idx] <= wb_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && vw_en) begin
            r_value[vw_idx] <= val;
        end
    end

endmodule

/* src/pooled_linked_list_manager_top.sv */
// Top level of the pooled linked list manager: stream ports, command and result registers.
//
//  Channel   Direction  Handshake                            Payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready    one list command
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready    one result per command
//
// One command per cycle while m_axis is ready; each result is registered on execution.
// Each command is a read-modify-write of the register-file pool and
// the head, tail, free and count registers between the command and result registers.
// Synchronous active-low reset rebuilds the descending free chain.
// A stalled result holds in the output register; the command register still fills,
// so o_s_axis_tready drops only when both registers hold a transaction.
module pooled_linked_list_manager_top
    import pllm_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // command[2:0], data_value[34:3], cursor_index[38:35], cursor_at_head[39]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // status[1:0], read_value[33:2], new_cursor_index[37:34], new_cursor_at_head[38],
    // element_count[43:39], list_empty[44], zero fill above
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_rsp;

    logic advance;
    logic in_take;
    t_rsp rsp;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    pllm_pool #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (advance),
        .i_req       (r_in),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command        <= t_cmd'(i_s_axis_tdata[S_CMD_LSB +: CMD_W]);
            r_in.data_value     <= i_s_axis_tdata[S_DATA_LSB +: DATA_W];
            r_in.cursor_index   <= i_s_axis_tdata[S_CUR_LSB +: CUR_W];
            r_in.cursor_at_head <= i_s_axis_tdata[S_HEAD_BIT];
        end
        if (advance) begin
            r_rsp <= rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata                               = '0;
        o_m_axis_tdata[M_STATUS_LSB +: STATUS_W]     = r_rsp.status;
        o_m_axis_tdata[M_VALUE_LSB +: DATA_W]        = r_rsp.read_value;
        o_m_axis_tdata[M_CUR_LSB +: CUR_W]           = r_rsp.new_cursor_index;
        o_m_axis_tdata[M_HEAD_BIT]                   = r_rsp.new_cursor_at_head;
        o_m_axis_tdata[M_COUNT_LSB +: COUNT_W]       = r_rsp.element_count;
        o_m_axis_tdata[M_EMPTY_BIT]                  = r_rsp.list_empty;
    end

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rsp.list_empty == (r_rsp.element_count == '0)))
        else $error("list_empty disagrees with element_count");

    a_head_cursor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.new_cursor_at_head) |-> (r_rsp.new_cursor_index == '0))
        else $error("head cursor returned with nonzero index");

    a_command_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && (r_rsp == $past(rsp))))
        else $error("executed command did not land in the result register");

    a_no_loss_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending command dropped while output stalled");

endmodule
